// ===== sv/mfpd_pkg.sv =====
// ----------------------------------------------------------------------------
// Motor fault persistence detector package
// Shared widths, register indexes, word layouts and control types.
// ----------------------------------------------------------------------------
package mfpd_pkg;

    localparam int HOLD_WIDTH   = 16;
    localparam int CUR_W        = 12;
    localparam int CMD_W        = 10;
    localparam int SPD_W        = 16;
    localparam int ERR_W        = 8;
    localparam int HOLD_REG_W   = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int NUM_DET      = 4;
    localparam int IN_DATA_W    = 48;
    localparam int OUT_DATA_W   = 16;

    localparam int DET_OVER     = 0;
    localparam int DET_ENC      = 1;
    localparam int DET_LOCK     = 2;
    localparam int DET_BREAK    = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OVER_LEVEL   = 3'd0,
        REG_OVER_HOLD    = 3'd1,
        REG_ENC_LEVEL    = 3'd2,
        REG_LOCK_LEVEL   = 3'd3,
        REG_BREAK_LEVEL  = 3'd4,
        REG_STALL_SPEED  = 3'd5,
        REG_QUAL_HOLD    = 3'd6,
        REG_FAULT_CODE   = 3'd7
    } t_reg_idx;

    localparam logic ACT_CHECK = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    typedef struct packed {
        logic [CUR_W-1:0]      over_level;
        logic [HOLD_REG_W-1:0] over_hold;
        logic [CUR_W-1:0]      enc_level;
        logic [CUR_W-1:0]      lock_level;
        logic [CUR_W-1:0]      break_level;
        logic [SPD_W-1:0]      stall_speed;
        logic [HOLD_REG_W-1:0] qual_hold;
        logic [ERR_W-1:0]      fault_code;
    } t_cfg;

    typedef struct packed {
        logic [ERR_W-1:0] error_in;
        logic [SPD_W-1:0] motor_speed;
        logic [CUR_W-1:0] measured_current;
        logic [CMD_W-1:0] command_current;
        logic             drive_en;
    } t_check;

    typedef struct packed {
        logic check;
        logic tick;
        logic cond;
    } t_det_ctl;

endpackage

// ===== sv/mfpd_cfg.sv =====
// ----------------------------------------------------------------------------
// Motor fault persistence detector configuration registers
// Write-only register file, always ready, reset to the default thresholds.
// ----------------------------------------------------------------------------
module mfpd_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mfpd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mfpd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output mfpd_pkg::t_cfg                o_cfg
);
    import mfpd_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_OVER_LEVEL:  n_cfg.over_level  = i_cfg_data[CUR_W-1:0];
                REG_OVER_HOLD:   n_cfg.over_hold   = i_cfg_data[HOLD_REG_W-1:0];
                REG_ENC_LEVEL:   n_cfg.enc_level   = i_cfg_data[CUR_W-1:0];
                REG_LOCK_LEVEL:  n_cfg.lock_level  = i_cfg_data[CUR_W-1:0];
                REG_BREAK_LEVEL: n_cfg.break_level = i_cfg_data[CUR_W-1:0];
                REG_STALL_SPEED: n_cfg.stall_speed = i_cfg_data[SPD_W-1:0];
                REG_QUAL_HOLD:   n_cfg.qual_hold   = i_cfg_data[HOLD_REG_W-1:0];
                REG_FAULT_CODE:  n_cfg.fault_code  = i_cfg_data[ERR_W-1:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.over_level  <= CUR_W'(4095);
            r_cfg.over_hold   <= HOLD_REG_W'(1000);
            r_cfg.enc_level   <= CUR_W'(8);
            r_cfg.lock_level  <= CUR_W'(40);
            r_cfg.break_level <= CUR_W'(4);
            r_cfg.stall_speed <= SPD_W'(1);
            r_cfg.qual_hold   <= HOLD_REG_W'(1000);
            r_cfg.fault_code  <= ERR_W'(1);
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== sv/mfpd_det.sv =====
// ----------------------------------------------------------------------------
// Motor fault persistence detector channel
// One armed flag and one saturating hold counter; fires on a persistent
// condition once the counter has run down.
// ----------------------------------------------------------------------------
module mfpd_det (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mfpd_pkg::t_det_ctl             i_ctl,
    input  logic [mfpd_pkg::HOLD_REG_W-1:0] i_hold,
    output logic                           o_fire
);
    import mfpd_pkg::*;

    logic                  r_armed;
    logic                  n_armed;
    logic [HOLD_WIDTH-1:0] r_cnt;
    logic [HOLD_WIDTH-1:0] n_cnt;

    assign o_fire = i_ctl.check && i_ctl.cond && r_armed && (r_cnt == '0);

    always_comb begin
        n_armed = r_armed;
        n_cnt   = r_cnt;
        if (i_ctl.check) begin
            if (!i_ctl.cond) begin
                n_armed = 1'b0;
            end else if (!r_armed) begin
                n_armed = 1'b1;
                n_cnt   = HOLD_WIDTH'(i_hold);
            end
        end
        if (i_ctl.tick && (r_cnt != '0)) begin
            n_cnt = r_cnt - HOLD_WIDTH'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_armed <= n_armed;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== sv/motor_fault_persistence_detector_core.sv =====
// ----------------------------------------------------------------------------
// Motor fault persistence detector core
// Overcurrent, encoder fault, motor lock and open circuit detectors with
// hold-time qualification and error code substitution.
// ----------------------------------------------------------------------------
// Input words arrive on the s_axis channel; s_axis_tuser selects a check
// (0) or a timer tick (1). A check word yields exactly one result word on
// m_axis; a tick word only decrements the hold counters and yields nothing.
// Each word passes an input register, then the detectors and a result
// register, which presents each check result on m_axis. One word
// per cycle is accepted while m_axis keeps up; the result register holds a
// waiting word, and s_axis_tready drops only when both the input and result
// registers are full and m_axis_tready is low (a tick still drains then).
// Configuration words on the cfg channel are always taken and must be sent
// while the block is idle. Reset (synchronous, active low) clears both
// registers, disarms all detectors, zeroes the hold counters and restores
// default thresholds.
// ----------------------------------------------------------------------------
module motor_fault_persistence_detector_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // drive_en, command_current, measured_current, motor_speed, error_in
    input  logic [mfpd_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // action
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // error_code, overcurrent_fault, encoder_fault, lock_fault, break_fault
    output logic [mfpd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mfpd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mfpd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import mfpd_pkg::*;

    t_cfg                  cfg;
    logic                  r_in_vld;
    logic                  r_in_tick;
    t_check                r_in;
    logic                  r_out_vld;
    logic [OUT_DATA_W-1:0] r_out;
    logic                  go;
    logic                  cmd_ok;
    logic                  stalled;
    logic [NUM_DET-1:0]    cond;
    logic [NUM_DET-1:0]    fire;
    t_det_ctl              ctl [NUM_DET];
    logic [HOLD_REG_W-1:0] hold [NUM_DET];
    logic [ERR_W-1:0]      code;

    mfpd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign go            = r_in_vld && (r_in_tick || !r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_tick <= s_axis_tuser;
            r_in      <= t_check'(s_axis_tdata[$bits(t_check)-1:0]);
        end
    end

    assign cmd_ok  = r_in.command_current != '0;
    assign stalled = r_in.motor_speed <= cfg.stall_speed;

    assign cond[DET_OVER]  = r_in.drive_en && (r_in.measured_current >= cfg.over_level);
    assign cond[DET_ENC]   = r_in.drive_en && cmd_ok && stalled
                             && (r_in.measured_current >= cfg.enc_level);
    assign cond[DET_LOCK]  = r_in.drive_en && cmd_ok && stalled
                             && (r_in.measured_current >= cfg.lock_level);
    assign cond[DET_BREAK] = r_in.drive_en && cmd_ok
                             && (r_in.measured_current <= cfg.break_level);

    assign hold[DET_OVER]  = cfg.over_hold;
    assign hold[DET_ENC]   = cfg.qual_hold;
    assign hold[DET_LOCK]  = cfg.qual_hold;
    assign hold[DET_BREAK] = cfg.qual_hold;

    for (genvar g = 0; g < NUM_DET; g++) begin : g_det
        assign ctl[g].check = go && (r_in_tick == ACT_CHECK);
        assign ctl[g].tick  = go && (r_in_tick == ACT_TICK);
        assign ctl[g].cond  = cond[g];

        mfpd_det u_det (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl[g]),
            .i_hold  (hold[g]),
            .o_fire  (fire[g])
        );
    end

    assign code = (|fire) ? cfg.fault_code : r_in.error_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (go && (r_in_tick == ACT_CHECK)) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && (r_in_tick == ACT_CHECK)) begin
            r_out <= {(OUT_DATA_W - ERR_W - NUM_DET)'(0), fire, code};
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;

    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_vld && r_out_vld && !m_axis_tready))
        else $error("input stalled without a pending word");

    a_tick_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_in_tick && m_axis_tvalid && m_axis_tready) |=> !m_axis_tvalid)
        else $error("tick word produced a result");

    a_fire_needs_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|fire) |-> (go && (r_in_tick == ACT_CHECK)))
        else $error("detector fired outside a check");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Motor fault persistence detector testbench
// Drives check and tick words into the core and models its four detectors to
// predict every result word. Directed words cover the arming check, counter
// saturation, disarm and rearm, field extremes and excess register bits.
// Random fault sequences then run under several threshold settings, with
// sender bursts, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
    import mfpd_pkg::*;

    localparam int NO_TARGET  = -1;
    localparam int RX_ALWAYS  = 0;
    localparam int RX_RANDOM  = 1;
    localparam int RX_PATTERN = 2;
    localparam int SETTLE     = 6;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
    logic                   s_axis_tuser  = ACT_CHECK;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;

    t_cfg                   cfg_model;
    logic                   armed [NUM_DET];
    logic [HOLD_WIDTH-1:0]  hold_cnt [NUM_DET];
    logic [OUT_DATA_W-1:0]  results_due [$];
    string                  flag_name [NUM_DET] = '{"overcurrent_fault", "encoder_fault",
                                                    "lock_fault", "break_fault"};
    int                     errors = 0;

    bit                     gaps_on = 1'b0;
    int                     burst_left = 0;
    int                     ready_mode = RX_ALWAYS;
    int                     hold_off_req = 0;
    int                     hold_off_len = 0;
    int                     hold_off_seen = 0;
    int                     hold_off_left = 0;
    int                     ready_phase = 0;

    motor_fault_persistence_detector_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [OUT_DATA_W-1:0] evaluate_detectors(input t_check w);
        logic                  cmd_ok;
        logic                  stalled;
        logic [NUM_DET-1:0]    cond;
        logic [NUM_DET-1:0]    fired;
        logic [ERR_W-1:0]      code;
        cmd_ok  = (w.command_current != '0);
        stalled = (w.motor_speed <= cfg_model.stall_speed);
        cond[DET_OVER]  = w.drive_en && (w.measured_current >= cfg_model.over_level);
        cond[DET_ENC]   = w.drive_en && cmd_ok && stalled &&
                          (w.measured_current >= cfg_model.enc_level);
        cond[DET_LOCK]  = w.drive_en && cmd_ok && stalled &&
                          (w.measured_current >= cfg_model.lock_level);
        cond[DET_BREAK] = w.drive_en && cmd_ok &&
                          (w.measured_current <= cfg_model.break_level);
        for (int d = 0; d < NUM_DET; d++) begin
            fired[d] = 1'b0;
            if (!cond[d]) begin
                armed[d] = 1'b0;
            end else if (!armed[d]) begin
                armed[d]    = 1'b1;
                hold_cnt[d] = HOLD_WIDTH'((d == DET_OVER) ? cfg_model.over_hold
                                                          : cfg_model.qual_hold);
            end else begin
                fired[d] = (hold_cnt[d] == '0);
            end
        end
        code = (fired != '0) ? cfg_model.fault_code : w.error_in;
        return {4'b0, fired[DET_BREAK], fired[DET_LOCK], fired[DET_ENC], fired[DET_OVER], code};
    endfunction

    function automatic void count_down_holds();
        for (int d = 0; d < NUM_DET; d++)
            if (hold_cnt[d] != '0)
                hold_cnt[d] = hold_cnt[d] - 1'b1;
    endfunction

    function automatic t_check check_of(input logic on, input int cmd, input int cur,
                                        input int spd, input int err);
        t_check w;
        w.drive_en         = on;
        w.command_current  = CMD_W'(cmd);
        w.measured_current = CUR_W'(cur);
        w.motor_speed      = SPD_W'(spd);
        w.error_in         = ERR_W'(err);
        return w;
    endfunction

    // pick field values that make the target detector's condition hold
    function automatic t_check make_check(input int target);
        t_check w;
        w.drive_en         = 1'b1;
        w.command_current  = CMD_W'($urandom_range(1, 1023));
        w.measured_current = CUR_W'($urandom);
        w.motor_speed      = SPD_W'($urandom);
        w.error_in         = ERR_W'($urandom);
        case (target)
            DET_OVER: begin
                w.measured_current = CUR_W'($urandom_range(cfg_model.over_level, 4095));
            end
            DET_ENC: begin
                w.measured_current = CUR_W'($urandom_range(cfg_model.enc_level, 4095));
                w.motor_speed      = SPD_W'($urandom_range(0, cfg_model.stall_speed));
            end
            DET_LOCK: begin
                w.measured_current = CUR_W'($urandom_range(cfg_model.lock_level, 4095));
                w.motor_speed      = SPD_W'($urandom_range(0, cfg_model.stall_speed));
            end
            DET_BREAK: begin
                w.measured_current = CUR_W'($urandom_range(0, cfg_model.break_level));
            end
            default: begin
                w.drive_en        = ($urandom_range(0, 3) != 0);
                w.command_current = ($urandom_range(0, 7) == 0) ? '0 : CMD_W'($urandom);
                if ($urandom_range(0, 1) == 0)
                    w.motor_speed = SPD_W'($urandom_range(0, cfg_model.stall_speed));
            end
        endcase
        return w;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= 40)
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    endtask

    always @(posedge i_clk) begin : check_results
        logic [OUT_DATA_W-1:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (results_due.size() == 0) begin
                report_mismatch("unexpected result word", m_axis_tdata, 0);
            end else begin
                want = results_due.pop_front();
                if (m_axis_tdata[ERR_W-1:0] !== want[ERR_W-1:0])
                    report_mismatch("error_code", m_axis_tdata[ERR_W-1:0], want[ERR_W-1:0]);
                for (int d = 0; d < NUM_DET; d++)
                    if (m_axis_tdata[ERR_W+d] !== want[ERR_W+d])
                        report_mismatch(flag_name[d], m_axis_tdata[ERR_W+d], want[ERR_W+d]);
            end
        end
    end

    always @(posedge i_clk) begin
        ready_phase <= (ready_phase + 1) % 7;
        if (hold_off_req != hold_off_seen) begin
            hold_off_seen <= hold_off_req;
            hold_off_left <= hold_off_len;
            m_axis_tready <= 1'b0;
        end else if (hold_off_left > 0) begin
            hold_off_left <= hold_off_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            case (ready_mode)
                RX_ALWAYS:  m_axis_tready <= 1'b1;
                RX_RANDOM:  m_axis_tready <= ($urandom_range(0, 2) != 0);
                default:    m_axis_tready <= (ready_phase < 4);
            endcase
        end
    end

    task automatic send_word(input logic action, input t_check word);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= action;
        s_axis_tdata  <= IN_DATA_W'(word);
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        if (action == ACT_TICK)
            count_down_holds();
        else
            results_due.push_back(evaluate_detectors(word));
        if (gaps_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap = $urandom_range(1, 6);
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            REG_OVER_LEVEL:  cfg_model.over_level  = value[CUR_W-1:0];
            REG_OVER_HOLD:   cfg_model.over_hold   = value[HOLD_REG_W-1:0];
            REG_ENC_LEVEL:   cfg_model.enc_level   = value[CUR_W-1:0];
            REG_LOCK_LEVEL:  cfg_model.lock_level  = value[CUR_W-1:0];
            REG_BREAK_LEVEL: cfg_model.break_level = value[CUR_W-1:0];
            REG_STALL_SPEED: cfg_model.stall_speed = value[SPD_W-1:0];
            REG_QUAL_HOLD:   cfg_model.qual_hold   = value[HOLD_REG_W-1:0];
            REG_FAULT_CODE:  cfg_model.fault_code  = value[ERR_W-1:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [15:0] over_level, input logic [15:0] over_hold,
                                  input logic [15:0] enc_level, input logic [15:0] lock_level,
                                  input logic [15:0] break_level, input logic [15:0] stall,
                                  input logic [15:0] qual_hold, input logic [15:0] code);
        write_reg(REG_OVER_LEVEL, over_level);
        write_reg(REG_OVER_HOLD, over_hold);
        write_reg(REG_ENC_LEVEL, enc_level);
        write_reg(REG_LOCK_LEVEL, lock_level);
        write_reg(REG_BREAK_LEVEL, break_level);
        write_reg(REG_STALL_SPEED, stall);
        write_reg(REG_QUAL_HOLD, qual_hold);
        write_reg(REG_FAULT_CODE, code);
    endtask

    task automatic apply_random_settings();
        apply_settings(16'($urandom), 16'($urandom_range(0, 3)), 16'($urandom),
                       16'($urandom), 16'($urandom_range(0, 600)),
                       16'($urandom_range(0, 65535)), 16'($urandom_range(0, 4)),
                       16'($urandom));
    endtask

    // hold one detector's condition over several checks, with ticks between
    task automatic run_fault_sequence(output int count);
        t_check base;
        t_check w;
        int     len;
        base = make_check($urandom_range(0, NUM_DET-1));
        len  = $urandom_range(2, 10);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 2) == 0) begin
                send_word(ACT_TICK, make_check(NO_TARGET));
            end else begin
                w = ($urandom_range(0, 7) == 0) ? make_check(NO_TARGET) : base;
                w.error_in = ERR_W'($urandom);
                send_word(ACT_CHECK, w);
            end
        end
        count = len;
    endtask

    task automatic test_random_traffic(input int n_words);
        int sent;
        int seq_len;
        int pick;
        int pause_at;
        sent     = 0;
        pause_at = $urandom_range(n_words / 4, 3 * n_words / 4);
        while (sent < n_words) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                run_fault_sequence(seq_len);
                sent += seq_len;
            end else begin
                send_word((pick == 7) ? ACT_TICK : ACT_CHECK, make_check(NO_TARGET));
                sent++;
            end
            if (pause_at >= 0 && sent >= pause_at) begin
                wait_for_results();
                pause_at = -1;
            end
        end
        wait_for_results();
    endtask

    task automatic test_reset_defaults();
        send_word(ACT_TICK, check_of(1'b0, 0, 0, 0, 0));
        send_word(ACT_CHECK, check_of(1'b0, 0, 0, 0, 0));
        send_word(ACT_CHECK, check_of(1'b1, 1023, 4095, 0, 255));
        send_word(ACT_CHECK, check_of(1'b1, 1023, 4095, 0, 255));
        send_word(ACT_CHECK, check_of(1'b1, 0, 0, 65535, 8'h5A));
        send_word(ACT_CHECK, check_of(1'b1, 1, 4, 65535, 8'hAA));
        send_word(ACT_CHECK, check_of(1'b0, 1023, 4095, 1, 8'h0F));
        send_word(ACT_CHECK, check_of(1'b1, 512, 40, 1, 8'hF0));
        wait_for_results();
    endtask

    task automatic test_hold_qualification();
        // excess register bits above each width must be dropped
        write_reg(REG_OVER_HOLD, 16'd0);
        write_reg(REG_QUAL_HOLD, 16'd2);
        write_reg(REG_OVER_LEVEL, 16'hF800);
        write_reg(REG_FAULT_CODE, 16'h01E5);
        send_word(ACT_CHECK, check_of(1'b1, 0, 12'h800, 1000, 8'h11));
        send_word(ACT_CHECK, check_of(1'b1, 0, 12'h800, 1000, 8'h12));
        send_word(ACT_TICK, check_of(1'b1, 0, 0, 0, 0));
        send_word(ACT_TICK, check_of(1'b1, 0, 0, 0, 0));
        send_word(ACT_CHECK, check_of(1'b1, 5, 2, 0, 8'h22));
        send_word(ACT_CHECK, check_of(1'b1, 5, 2, 0, 8'h23));
        send_word(ACT_TICK, check_of(1'b0, 0, 0, 0, 0));
        send_word(ACT_CHECK, check_of(1'b1, 5, 2, 0, 8'h24));
        send_word(ACT_TICK, check_of(1'b0, 0, 0, 0, 0));
        send_word(ACT_CHECK, check_of(1'b1, 5, 2, 0, 8'h25));
        send_word(ACT_TICK, check_of(1'b0, 0, 0, 0, 0));
        send_word(ACT_CHECK, check_of(1'b1, 5, 2, 0, 8'h26));
        send_word(ACT_CHECK, check_of(1'b1, 5, 100, 0, 8'h27));
        send_word(ACT_CHECK, check_of(1'b1, 5, 3, 0, 8'h28));
        wait_for_results();
    endtask

    task automatic test_backpressure();
        ready_mode   <= RX_ALWAYS;
        gaps_on      = 1'b0;
        hold_off_len <= 80;
        hold_off_req <= hold_off_req + 1;
        for (int k = 0; k < 40; k++)
            send_word(($urandom_range(0, 4) == 0) ? ACT_TICK : ACT_CHECK,
                      make_check(($urandom_range(0, 1) == 0) ? NO_TARGET
                                                             : $urandom_range(0, NUM_DET-1)));
        wait_for_results();
    endtask

    initial begin
        cfg_model = '{over_level: 12'd4095, over_hold: 16'd1000, enc_level: 12'd8,
                      lock_level: 12'd40, break_level: 12'd4, stall_speed: 16'd1,
                      qual_hold: 16'd1000, fault_code: 8'd1};
        for (int d = 0; d < NUM_DET; d++) begin
            armed[d]    = 1'b0;
            hold_cnt[d] = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_hold_qualification();

        ready_mode <= RX_RANDOM;
        gaps_on    = 1'b1;
        apply_random_settings();
        test_random_traffic(400);

        ready_mode <= RX_ALWAYS;
        gaps_on    = 1'b0;
        apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        test_random_traffic(200);

        ready_mode <= RX_PATTERN;
        gaps_on    = 1'b1;
        apply_settings(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                       16'hFFFF, 16'hFF);
        test_random_traffic(200);

        apply_random_settings();
        test_backpressure();

        ready_mode <= RX_PATTERN;
        gaps_on    = 1'b1;
        apply_random_settings();
        test_random_traffic(250);

        ready_mode <= RX_RANDOM;
        gaps_on    = 1'b0;
        apply_random_settings();
        test_random_traffic(300);

        wait_for_results();
        if (errors == 0 && results_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
